// ----- rtl/sfda_pkg.sv -----
// ----------------------------------------------------------------------------
// sfda_pkg: shared types and constants for the fixed-point to ASCII unit
// Character codes, field geometry and the divide-by-ten reciprocal.
// ----------------------------------------------------------------------------
package sfda_pkg;

  localparam int VALUE_W       = 64;
  localparam int FIELD_CHARS   = 10;
  localparam int FRAC_BITS_DEF = 32;
  localparam int CHAR_W        = 7;

  // Integer digits below the overflow limit, and the digit budget.
  localparam int INT_DIGITS    = 9;
  localparam int DIGITS_BUDGET = 7;
  localparam int FRAC_DIGITS   = DIGITS_BUDGET - 1;

  // Integer part below 10^9 fits in 30 bits.
  localparam int IPART_W = 30;
  localparam logic [VALUE_W-1:0] INT_LIMIT = 64'd1000000000;

  // floor(t / 10) == (t * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit t.
  localparam int            MAGIC_W     = 32;
  localparam logic [31:0]   DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int            DIV10_SHIFT = 35;

  typedef logic [3:0]        digit_t;
  typedef logic [CHAR_W-1:0] char_t;

  localparam char_t CH_SPACE = 7'h20;
  localparam char_t CH_ZERO  = 7'h30;
  localparam char_t CH_POINT = 7'h2E;
  localparam char_t CH_MINUS = 7'h2D;

endpackage

// ----- rtl/sfda_ifs.sv -----
// ----------------------------------------------------------------------------
// sfda stream interfaces
// Valid/ready channels for the input number and the ASCII result field.
// ----------------------------------------------------------------------------
interface sfda_in_if;
  import sfda_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sfda_out_if;
  import sfda_pkg::*;

  logic  valid;
  logic  ready;
  char_t char0;
  char_t char1;
  char_t char2;
  char_t char3;
  char_t char4;
  char_t char5;
  char_t char6;
  char_t char7;
  char_t char8;
  char_t char9;
  logic  overflow;

  modport source (output valid, output char0, output char1, output char2, output char3,
                  output char4, output char5, output char6, output char7, output char8,
                  output char9, output overflow, input ready);
  modport sink   (input valid, input char0, input char1, input char2, input char3,
                  input char4, input char5, input char6, input char7, input char8,
                  input char9, input overflow, output ready);
endinterface

// ----- rtl/signed_fixed_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// signed_fixed_to_decimal_ascii_unit: signed fixed-point to decimal ASCII
// Turns a two's complement fixed-point number into a ten-character,
// right-aligned, space-padded decimal field with an overflow flag.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake        Payload
//  -------  ---  ---------------  ------------------------------------------
//  in_i     in   valid / ready    value (64 b signed, FRAC_BITS fraction bits)
//  out_o    out  valid / ready    char0..char9 (7 b ASCII), overflow (1 b)
//
//  One item enters per cycle unless the output stalls; each result passes S0,
//  S1, the nine divide-by-ten stages that peel off integer digits, A and B.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  When the output item is not taken, the whole pipeline holds and in_i.ready
//  drops. An empty output register never holds the pipeline; bubbles inside
//  it are not compressed, they travel along with the items.
//
//  Pipeline:
//    S0      take magnitude and sign
//    S1      split integer and fraction, check the 10^9 limit
//    D1..D9  one integer digit per stage (reciprocal multiply), and in the
//            first six stages one fraction digit (times ten)
//    A       count integer digits, size the fraction after zero stripping
//    B       place characters into the field (output register)
// ----------------------------------------------------------------------------
module signed_fixed_to_decimal_ascii_unit #(
  parameter int FRAC_BITS = sfda_pkg::FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sfda_in_if.sink           in_i,
  sfda_out_if.source        out_o
);
  import sfda_pkg::*;

  localparam int NSTG   = INT_DIGITS + 1;  // S1 plus the digit stages
  localparam int PROD_W = IPART_W + MAGIC_W;
  localparam int FPRD_W = FRAC_BITS + 4;

  // Global advance: move everything when the output slot is free or taken.
  logic adv;
  logic vb_q;

  assign adv        = !vb_q || out_o.ready;
  assign in_i.ready = adv;

  // --------------------------------------------------------------------------
  // S0: sign and magnitude (most negative value keeps magnitude 2^63)
  // --------------------------------------------------------------------------
  logic               v0_q;
  logic               neg0_q;
  logic [VALUE_W-1:0] mag0_q;
  logic [VALUE_W-1:0] raw;

  assign raw = $unsigned(in_i.value);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg0_q <= raw[VALUE_W-1];
      mag0_q <= raw[VALUE_W-1] ? (~raw + 64'd1) : raw;
    end
  end

  // --------------------------------------------------------------------------
  // Stage arrays: index 0 is S1, index s is the output of digit stage s.
  // --------------------------------------------------------------------------
  logic                 v_q   [NSTG];
  logic                 neg_q [NSTG];
  logic                 ovf_q [NSTG];
  logic                 fnz_q [NSTG];
  logic [IPART_W-1:0]   t_q   [NSTG];
  logic [FRAC_BITS-1:0] fr_q  [NSTG];
  digit_t               dg_q  [NSTG][INT_DIGITS];
  digit_t               fd_q  [NSTG][FRAC_DIGITS];

  // S1: split and limit check
  logic [VALUE_W-1:0] ipart;

  assign ipart = mag0_q >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      neg_q[0] <= neg0_q;
      ovf_q[0] <= (ipart >= INT_LIMIT);
      fnz_q[0] <= |mag0_q[FRAC_BITS-1:0];
      t_q[0]   <= ipart[IPART_W-1:0];
      fr_q[0]  <= mag0_q[FRAC_BITS-1:0];
      dg_q[0]  <= '{default: '0};
      fd_q[0]  <= '{default: '0};
    end
  end

  // --------------------------------------------------------------------------
  // Digit stages: integer digit s-1 (least significant first) and, for the
  // first six stages, fraction digit s-1 (most significant first).
  // --------------------------------------------------------------------------
  for (genvar s = 1; s < NSTG; s++) begin : g_dig
    logic [PROD_W-1:0]  prod;
    logic [IPART_W-1:0] quot;
    digit_t             rem;
    logic [FPRD_W-1:0]  fx;
    digit_t             dg_d [INT_DIGITS];
    digit_t             fd_d [FRAC_DIGITS];

    always_comb begin
      prod = PROD_W'(t_q[s-1]) * PROD_W'(DIV10_MAGIC);
      quot = IPART_W'(prod >> DIV10_SHIFT);
      rem  = 4'(t_q[s-1] - ((quot << 3) + (quot << 1)));
      fx   = (FPRD_W'(fr_q[s-1]) << 3) + (FPRD_W'(fr_q[s-1]) << 1);
      dg_d      = dg_q[s-1];
      dg_d[s-1] = rem;
      fd_d      = fd_q[s-1];
      if (s <= FRAC_DIGITS) begin
        fd_d[(s-1) % FRAC_DIGITS] = fx[FPRD_W-1:FRAC_BITS];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (adv) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        neg_q[s] <= neg_q[s-1];
        ovf_q[s] <= ovf_q[s-1];
        fnz_q[s] <= fnz_q[s-1];
        t_q[s]   <= quot;
        fr_q[s]  <= fx[FRAC_BITS-1:0];
        dg_q[s]  <= dg_d;
        fd_q[s]  <= fd_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage A: digit count and fraction length after trailing zeros are dropped
  // --------------------------------------------------------------------------
  localparam int LST = NSTG - 1;

  logic       va_q;
  logic       nega_q;
  logic       ovfa_q;
  logic       fnza_q;
  digit_t     dga_q [INT_DIGITS];
  digit_t     fda_q [FRAC_DIGITS];
  logic [3:0] nda_q;
  logic [2:0] nea_q;

  logic [3:0] nd_d;
  logic [2:0] ne_d;

  always_comb begin
    int nf;
    nd_d = 4'd1;
    for (int k = 1; k < INT_DIGITS; k++) begin
      if (dg_q[LST][k] != 4'd0) nd_d = 4'(k + 1);
    end
    nf = DIGITS_BUDGET - int'(nd_d) - int'(neg_q[LST]);
    // Keep the last nonzero fraction digit within the budget.
    ne_d = 3'd0;
    for (int m = 1; m <= FRAC_DIGITS; m++) begin
      if (m <= nf && fd_q[LST][m-1] != 4'd0) ne_d = 3'(m);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= v_q[LST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nega_q <= neg_q[LST];
      ovfa_q <= ovf_q[LST];
      fnza_q <= fnz_q[LST];
      dga_q  <= dg_q[LST];
      fda_q  <= fd_q[LST];
      nda_q  <= nd_d;
      nea_q  <= ne_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: place characters, column 0 is the rightmost. A sign that does
  // not fit (nine digits and a point) falls off the left edge.
  // --------------------------------------------------------------------------
  char_t col_d [FIELD_CHARS];
  char_t col_q [FIELD_CHARS];
  logic  ovfb_q;

  always_comb begin
    int off;
    int ne;
    int nd;
    int ip;
    ne  = int'(nea_q);
    nd  = int'(nda_q);
    off = fnza_q ? ne + 1 : 0;
    for (int j = 0; j < FIELD_CHARS; j++) begin
      ip = j - off;
      if (ovfa_q) begin
        col_d[j] = CH_SPACE;
      end else if (fnza_q && j < ne) begin
        col_d[j] = CH_ZERO + char_t'(fda_q[3'(ne - 1 - j)]);
      end else if (fnza_q && j == ne) begin
        col_d[j] = CH_POINT;
      end else if (ip >= 0 && ip < nd) begin
        col_d[j] = CH_ZERO + char_t'(dga_q[4'(ip)]);
      end else if (ip == nd && nega_q) begin
        col_d[j] = CH_MINUS;
      end else begin
        col_d[j] = CH_SPACE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col_q  <= col_d;
      ovfb_q <= ovfa_q;
    end
  end

  // Drive the field, leftmost character first.
  assign out_o.valid    = vb_q;
  assign out_o.char0    = col_q[9];
  assign out_o.char1    = col_q[8];
  assign out_o.char2    = col_q[7];
  assign out_o.char3    = col_q[6];
  assign out_o.char4    = col_q[5];
  assign out_o.char5    = col_q[4];
  assign out_o.char6    = col_q[3];
  assign out_o.char7    = col_q[2];
  assign out_o.char8    = col_q[1];
  assign out_o.char9    = col_q[0];
  assign out_o.overflow = ovfb_q;

endmodule

// ----- dv/decimal_field_checker.sv -----
// ----------------------------------------------------------------------------
// decimal_field_checker: result predictor and comparator
// Watches both channels of the fixed-point to ASCII unit, formats every
// accepted number into its expected ten-character field and compares each
// result item with the oldest expected field.
// ----------------------------------------------------------------------------
module decimal_field_checker #(
  parameter int FRAC_BITS = sfda_pkg::FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  sfda_in_if          in_mon_i,
  sfda_out_if         out_mon_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import sfda_pkg::*;

  localparam int MAX_PRINTED = 40;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    char_t                     ch[FIELD_CHARS];
    logic                      overflow;
  } ascii_field_t;

  ascii_field_t expected_fields[$];
  int unsigned  mismatch_count = 0;
  int unsigned  outstanding    = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = outstanding;

  task automatic report_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) begin
      $display("MISMATCH at %0t: %s", $realtime, what);
    end
  endtask

  // Build the field left to right as a character stream; the field keeps the
  // last ten characters, so a sign that does not fit falls off the left.
  function automatic ascii_field_t format_decimal_field(logic signed [VALUE_W-1:0] value);
    ascii_field_t       f;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] ipart;
    logic [VALUE_W-1:0] frac;
    logic [VALUE_W-1:0] t;
    logic               neg;
    char_t              digits[INT_DIGITS];
    char_t              text[$];
    int                 n_int;
    int                 n_frac;
    int                 i;
    int                 j;
    int                 k;
    neg    = value[VALUE_W-1];
    mag    = neg ? (~value) + 64'd1 : value;
    mask   = (64'd1 << FRAC_BITS) - 64'd1;
    ipart  = mag >> FRAC_BITS;
    frac   = mag & mask;
    f.value    = value;
    f.overflow = 1'b0;
    for (i = 0; i < FIELD_CHARS; i++) f.ch[i] = CH_SPACE;
    if (ipart >= INT_LIMIT) begin
      f.overflow = 1'b1;
      return f;
    end
    t     = ipart;
    n_int = 0;
    do begin
      digits[n_int] = CH_ZERO + char_t'(t % 10);
      t             = t / 10;
      n_int++;
    end while (t != 0 && n_int < INT_DIGITS);
    if (neg) text.push_back(CH_MINUS);
    for (i = n_int - 1; i >= 0; i--) text.push_back(digits[i]);
    if (frac != 0) begin
      text.push_back(CH_POINT);
      n_frac = DIGITS_BUDGET - n_int - (neg ? 1 : 0);
      for (i = 0; i < n_frac; i++) begin
        frac = frac * 10;
        text.push_back(CH_ZERO + char_t'(frac >> FRAC_BITS));
        frac = frac & mask;
      end
    end
    for (i = 0; i < FIELD_CHARS; i++) begin
      j = text.size() - FIELD_CHARS + i;
      if (j >= 0) f.ch[i] = text[j];
    end
    // Strip trailing zero digits by shifting right; the point stops it.
    if (frac != 0 || text[text.size()-1] == CH_ZERO && text.size() > n_int + (neg ? 1 : 0)) begin
      for (k = FIELD_CHARS - 1; k > 0 && f.ch[FIELD_CHARS-1] == CH_ZERO; k--) begin
        for (j = FIELD_CHARS - 1; j > 0; j--) f.ch[j] = f.ch[j-1];
        f.ch[0] = CH_SPACE;
      end
    end
    return f;
  endfunction

  always @(posedge clk_i) begin
    ascii_field_t exp_f;
    char_t        got[FIELD_CHARS];
    if (rst_ni) begin
      if (in_mon_i.valid && in_mon_i.ready) begin
        expected_fields.push_back(format_decimal_field(in_mon_i.value));
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got = '{out_mon_i.char0, out_mon_i.char1, out_mon_i.char2, out_mon_i.char3,
                out_mon_i.char4, out_mon_i.char5, out_mon_i.char6, out_mon_i.char7,
                out_mon_i.char8, out_mon_i.char9};
        if (expected_fields.size() == 0) begin
          report_mismatch("result item with no input item waiting");
        end else begin
          exp_f = expected_fields.pop_front();
          for (int i = 0; i < FIELD_CHARS; i++) begin
            if (got[i] !== exp_f.ch[i]) begin
              report_mismatch($sformatf("value %h char%0d: got %h expected %h",
                                        exp_f.value, i, got[i], exp_f.ch[i]));
            end
          end
          if (out_mon_i.overflow !== exp_f.overflow) begin
            report_mismatch($sformatf("value %h overflow: got %b expected %b",
                                      exp_f.value, out_mon_i.overflow, exp_f.overflow));
          end
        end
      end
      outstanding <= expected_fields.size();
    end
  end

endmodule

// ----- dv/tb_signed_fixed_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// tb_signed_fixed_to_decimal_ascii_unit: testbench top
// Drives directed and random fixed-point numbers into the converter with
// random idle gaps on both channels, including one long output hold-off,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_signed_fixed_to_decimal_ascii_unit;
  import sfda_pkg::*;

  localparam int FRAC_BITS       = FRAC_BITS_DEF;
  localparam int RANDOM_ITEMS    = 800;
  // One long output hold-off once this many items have gone in.
  localparam int PRESSURE_AT     = 300;
  localparam int PRESSURE_CYCLES = 300;
  // Window of items with no idling on either side.
  localparam int CALM_FROM       = 450;
  localparam int CALM_TO         = 550;
  // Pipeline depth is 13; leave slack for the final quiet check.
  localparam int TAIL_CYCLES     = 30;
  localparam int DRAIN_LIMIT     = 5000;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned accepted = 0;
  logic        calm;
  logic        backpressure_done = 1'b0;

  sfda_in_if  in_if ();
  sfda_out_if out_if ();

  signed_fixed_to_decimal_ascii_unit #(
    .FRAC_BITS (FRAC_BITS)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  decimal_field_checker #(
    .FRAC_BITS (FRAC_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon_i     (in_if),
    .out_mon_i    (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  assign calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_cycles();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  // Assemble a fixed-point number from sign, integer part and fraction bits.
  function automatic logic signed [VALUE_W-1:0] make_fixed(logic neg,
                                                           logic [VALUE_W-1:0] ipart,
                                                           logic [VALUE_W-1:0] frac);
    logic [VALUE_W-1:0] mag;
    mag = (ipart << FRAC_BITS) | frac;
    return neg ? -mag : mag;
  endfunction

  // Mostly well-formed numbers with a random count of integer digits and a
  // fraction shaped to hit digit truncation and zero stripping; the rest is
  // raw 64-bit noise and values around the overflow limit.
  function automatic logic signed [VALUE_W-1:0] random_value();
    int unsigned        pick;
    int unsigned        n_dig;
    logic [VALUE_W-1:0] lo;
    logic [VALUE_W-1:0] ipart;
    logic [VALUE_W-1:0] frac;
    pick = $urandom_range(0, 99);
    if (pick < 10) return {$urandom, $urandom};
    if (pick < 16) begin
      ipart = 64'd999999998 + 64'($urandom_range(0, 3));
      return make_fixed(1'($urandom_range(0, 1)), ipart, 64'($urandom));
    end
    n_dig = $urandom_range(0, INT_DIGITS);
    lo    = 64'd1;
    if (n_dig > 1) begin
      repeat (n_dig - 1) lo = lo * 64'd10;
    end
    ipart = (n_dig == 0) ? 64'd0
                         : 64'($urandom_range(32'(lo), 32'(lo * 64'd10 - 64'd1)));
    case ($urandom_range(0, 4))
      0:       frac = '0;
      1:       frac = 64'({4'($urandom_range(1, 15)), 28'd0});
      2:       frac = 64'($urandom_range(1, 1000));
      default: frac = 64'($urandom);
    endcase
    return make_fixed(1'($urandom_range(0, 1)), ipart, frac);
  endfunction

  // Offer one item and hold it until taken; then maybe drop valid for a gap.
  task automatic send_value(logic signed [VALUE_W-1:0] value);
    in_if.valid <= 1'b1;
    in_if.value <= value;
    do @(posedge clk_i); while (!in_if.ready);
    accepted++;
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      in_if.value <= {$urandom, $urandom};
      repeat (idle_cycles()) @(negedge clk_i);
    end
  endtask

  // Result side: random stalls, one long hold-off while the sender keeps
  // offering so the pipeline fills and in_i.ready drops.
  initial begin : result_sink
    int unsigned hold;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!backpressure_done && accepted >= PRESSURE_AT) begin
        out_if.ready <= 1'b0;
        hold = 0;
        while (hold < PRESSURE_CYCLES) begin
          @(negedge clk_i);
          hold++;
        end
        backpressure_done = 1'b1;
      end else if (calm || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b0;
        repeat (idle_cycles() - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : value_source
    int unsigned drain;
    rst_ni       = 1'b0;
    in_if.valid <= 1'b0;
    in_if.value <= '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: zero, unit values, extremes of the input range, the overflow
    // limit on both sides, fraction digit budget running out, zero stripping
    // down to the bare point, and the minus sign pushed out of a full field.
    send_value('0);
    send_value(make_fixed(1'b0, 64'd1, 64'd0));
    send_value(make_fixed(1'b1, 64'd1, 64'd0));
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(make_fixed(1'b0, 64'd0, 64'd1));
    send_value(make_fixed(1'b0, 64'd0, 64'h8000_0000));
    send_value(make_fixed(1'b1, 64'd0, 64'h8000_0000));
    send_value(make_fixed(1'b0, 64'd0, 64'hFFFF_FFFF));
    send_value(make_fixed(1'b0, 64'd12, 64'h4000_0000));
    send_value(make_fixed(1'b0, 64'd7, 64'h0CCC_CCCD));
    send_value(make_fixed(1'b0, 64'd123456, 64'hC000_0000));
    send_value(make_fixed(1'b1, 64'd123456, 64'h8000_0000));
    send_value(make_fixed(1'b0, 64'd1234567, 64'd1));
    send_value(make_fixed(1'b0, 64'd100000000, 64'd0));
    send_value(make_fixed(1'b0, 64'd999999999, 64'hFFFF_FFFF));
    send_value(make_fixed(1'b1, 64'd999999999, 64'h8000_0000));
    send_value(make_fixed(1'b1, 64'd999999999, 64'hFFFF_FFFF));
    send_value(make_fixed(1'b1, 64'd999999999, 64'd0));
    send_value(make_fixed(1'b0, 64'd1000000000, 64'd0));
    send_value(make_fixed(1'b1, 64'd1000000000, 64'd0));
    send_value(make_fixed(1'b1, 64'd1000000000, 64'd1));

    repeat (RANDOM_ITEMS) send_value(random_value());
    in_if.valid <= 1'b0;

    // Drain the pipeline, then stay a little longer to catch stray results.
    drain = 0;
    while (pending != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/sfda_pkg.sv
rtl/sfda_ifs.sv
rtl/signed_fixed_to_decimal_ascii_unit.sv
dv/decimal_field_checker.sv
dv/tb_signed_fixed_to_decimal_ascii_unit.sv
